FILE: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tah_pkg.sv
`default_nettype none
package tah_pkg;
    localparam int MAX_CLASSES_DEF = 64;
    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int CORDIC_STEPS    = 24;
    localparam int STEP_W          = 5;
    localparam int BINCFG_W        = 7;
    localparam logic [BINCFG_W-1:0] BINCFG_RESET = 7'd64;

    function automatic logic [31:0] arc_lookup(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        unique case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680862;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            default: r = 32'd0;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/turn_angle_histogram_unit.sv
`default_nettype none
// Turning-angle histogram. Send the vertices of a closed polygon, the last one with tlast.
// A vertex after the second passes through the accepting cycle, the 24-step iterative cordic
// of the incoming edge direction, then a read-modify-write of the class memory (ST_RD,
// ST_RMW, ST_WR). The second vertex only sets the opening direction, and the first only
// stores the start point. A zero-length edge skips the cordic iterations. In a polygon of
// three or more vertices the closing vertex adds a second direction, two updates and one
// beat per class in use (bin_count); every closing vertex then starts a clear sweep over
// the class memory. After reset the same clear sweep runs before the first vertex is taken.
// Each beat on m_ carries one class; tlast marks the last class.
module turn_angle_histogram_unit #(
    parameter int MAX_CLASSES = tah_pkg::MAX_CLASSES_DEF,
    parameter int COORD_WIDTH = tah_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = tah_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2*COORD_WIDTH-1:0] s_tdata, // vertex_x, vertex_y
    input  wire logic        s_tlast,             // closes_polygon
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,             // bin_index, bin_hits, vertex_total
    output logic             m_tlast              // final_bin
);
    import tah_pkg::*;
    localparam int COUNT_WIDTH = COUNT_WIDTH_DEF;
    localparam int IDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int CNT_W = IDX_W + 1;

    localparam logic [3:0] ST_CLEAR = 4'd0, ST_IDLE = 4'd1, ST_DIR = 4'd2, ST_RD = 4'd3,
                           ST_RMW = 4'd4, ST_WR = 4'd5, ST_CDIR = 4'd6, ST_EMIT = 4'd7,
                           ST_EWAIT = 4'd8, ST_OUT = 4'd9;
    localparam logic [1:0] PH_EDGE = 2'd0, PH_CLOSE = 2'd1, PH_OPEN = 2'd2;

    logic [3:0] st_reg, st_next;
    logic [BINCFG_W-1:0] bincfg_reg;
    logic signed [COORD_WIDTH-1:0] fx_reg, fy_reg, px_reg, py_reg, vx, vy;
    logic [ANGLE_WIDTH-1:0] open_reg, inc_reg, cdir_reg;
    logic [15:0] seen_reg, seen_next;
    logic last_reg;
    logic [1:0] phase_reg;
    logic [IDX_W-1:0] k_reg, bin_reg;
    logic [CNT_W-1:0] n_use;

    logic cstart, cdone;
    logic signed [COORD_WIDTH:0] cdx, cdy;
    logic [ANGLE_WIDTH-1:0] cang;

    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic [COUNT_WIDTH-1:0] rd_data, wr_data;
    logic wr_en;

    logic [ANGLE_WIDTH-1:0] a_in, a_out, ang;
    logic [ANGLE_WIDTH+CNT_W-1:0] prod;
    logic [CNT_W-1:0] bsel;

    logic [5:0]  o_idx_reg;
    logic [15:0] o_hits_reg, o_tot_reg;
    logic        o_last_reg, o_valid_reg;

    assign vx = s_tdata[COORD_WIDTH-1:0];
    assign vy = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];

    always_comb begin
        if (bincfg_reg == '0) n_use = CNT_W'(1);
        else if (bincfg_reg > BINCFG_W'(MAX_CLASSES)) n_use = CNT_W'(MAX_CLASSES);
        else n_use = CNT_W'(bincfg_reg);
    end

    tah_cordic #(.COORD_WIDTH(COORD_WIDTH), .ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cstart), .dx(cdx), .dy(cdy),
        .done(cdone), .angle(cang)
    );

    tah_store #(.MAX_CLASSES(MAX_CLASSES), .COUNT_WIDTH(COUNT_WIDTH)) u_store (
        .aclk(aclk), .rd_addr(rd_addr), .rd_data(rd_data),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
    );

    // class of the pending tally, from the latest cordic angle or the closing pair
    always_comb begin
        if (st_reg == ST_RD && phase_reg == PH_OPEN) begin
            a_in = cdir_reg;
            a_out = open_reg;
        end else begin
            a_in = inc_reg;
            a_out = cdir_reg;
        end
        ang  = ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 1)) + a_in - a_out;
        prod = (ANGLE_WIDTH+CNT_W)'(ang) * (ANGLE_WIDTH+CNT_W)'(n_use);
        bsel = prod[ANGLE_WIDTH +: CNT_W];
        if (bsel >= n_use) bsel = n_use - 1'b1;
    end

    assign s_tready = (st_reg == ST_IDLE);
    wire s_fire = s_tvalid && s_tready;
    wire m_free = !o_valid_reg || m_tready;

    always_comb begin
        st_next = st_reg;
        seen_next = (seen_reg == 16'hFFFF) ? seen_reg : seen_reg + 1'b1;
        cstart = 1'b0;
        cdx = '0;
        cdy = cdx;
        rd_addr = bin_reg;
        wr_en = 1'b0;
        wr_addr = bin_reg;
        wr_data = (rd_data == '1) ? rd_data : rd_data + 1'b1;
        unique case (st_reg)
            ST_CLEAR: begin
                wr_en = 1'b1;
                wr_addr = k_reg;
                wr_data = '0;
                if (k_reg == IDX_W'(MAX_CLASSES - 1)) st_next = ST_IDLE;
            end
            ST_IDLE: begin
                cdx = {vx[COORD_WIDTH-1], vx} - {px_reg[COORD_WIDTH-1], px_reg};
                cdy = {vy[COORD_WIDTH-1], vy} - {py_reg[COORD_WIDTH-1], py_reg};
                if (s_fire) begin
                    if (seen_reg != 16'd0) begin
                        cstart = 1'b1;
                        st_next = ST_DIR;
                    end else if (s_tlast) begin
                        st_next = ST_CLEAR;
                    end
                end
            end
            ST_DIR: begin
                if (cdone) begin
                    if (seen_reg >= 16'd3) st_next = ST_RD;
                    else if (last_reg && seen_reg >= 16'd3) st_next = ST_RD;
                    else if (last_reg) st_next = ST_CLEAR;
                    else st_next = ST_IDLE;
                end
            end
            ST_RD: begin
                rd_addr = bsel[IDX_W-1:0];
                st_next = ST_RMW;
            end
            ST_RMW: st_next = ST_WR;
            ST_WR: begin
                wr_en = 1'b1;
                if (!last_reg) st_next = ST_IDLE;
                else if (phase_reg == PH_EDGE) begin
                    cstart = 1'b1;
                    cdx = {fx_reg[COORD_WIDTH-1], fx_reg} - {px_reg[COORD_WIDTH-1], px_reg};
                    cdy = {fy_reg[COORD_WIDTH-1], fy_reg} - {py_reg[COORD_WIDTH-1], py_reg};
                    st_next = ST_CDIR;
                end else if (phase_reg == PH_CLOSE) begin
                    st_next = ST_RD;
                end else begin
                    st_next = ST_EMIT;
                end
            end
            ST_CDIR: if (cdone) st_next = ST_RD;
            ST_EMIT: begin
                rd_addr = k_reg;
                st_next = ST_EWAIT;
            end
            ST_EWAIT: begin
                rd_addr = k_reg;
                if (m_free) st_next = ST_OUT;
            end
            ST_OUT: begin
                rd_addr = k_reg;
                if (m_free) st_next = o_last_reg ? ST_CLEAR : ST_EMIT;
            end
            default: st_next = ST_CLEAR;
        endcase
    end

    // sequencer; closing runs tally(inc, cdir) then tally(cdir, open), then emits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_CLEAR;
            k_reg <= '0;
            bincfg_reg <= BINCFG_RESET;
            seen_reg <= '0;
            last_reg <= 1'b0;
            phase_reg <= PH_EDGE;
            o_valid_reg <= 1'b0;
            fx_reg <= '0; fy_reg <= '0; px_reg <= '0; py_reg <= '0;
            open_reg <= '0; inc_reg <= '0;
        end else begin
            if (cfg_wr_en) bincfg_reg <= cfg_wr_data;
            if (st_reg == ST_EWAIT && m_free) o_valid_reg <= 1'b1;
            else if (m_tready) o_valid_reg <= 1'b0;
            unique case (st_reg)
                ST_CLEAR: begin
                    k_reg <= (k_reg == IDX_W'(MAX_CLASSES - 1)) ? '0 : k_reg + 1'b1;
                    seen_reg <= '0;
                    last_reg <= 1'b0;
                    phase_reg <= PH_EDGE;
                    fx_reg <= '0; fy_reg <= '0; px_reg <= '0; py_reg <= '0;
                    open_reg <= '0; inc_reg <= '0;
                end
                ST_IDLE: begin
                    if (s_fire) begin
                        if (seen_reg == 16'd0) begin
                            fx_reg <= vx;
                            fy_reg <= vy;
                        end
                        px_reg <= vx;
                        py_reg <= vy;
                        seen_reg <= seen_next;
                        last_reg <= s_tlast;
                        k_reg <= '0;
                    end
                end
                ST_DIR: begin
                    if (cdone) begin
                        cdir_reg <= cang;
                        if (seen_reg == 16'd2) open_reg <= cang;
                        if (seen_reg < 16'd3) begin
                            inc_reg <= cang;
                        end
                    end
                end
                ST_RD: bin_reg <= bsel[IDX_W-1:0];
                ST_RMW: ;
                ST_WR: begin
                    if (phase_reg == PH_EDGE) inc_reg <= cdir_reg;
                    if (phase_reg == PH_CLOSE) phase_reg <= PH_OPEN;
                end
                ST_CDIR: begin
                    if (cdone) begin
                        cdir_reg <= cang;
                        phase_reg <= PH_CLOSE;
                    end
                end
                ST_EMIT: ;
                ST_EWAIT: begin
                    if (m_free) begin
                        o_idx_reg <= 6'(k_reg);
                        o_hits_reg <= 16'(rd_data);
                        o_tot_reg <= seen_reg;
                        o_last_reg <= (CNT_W'(k_reg) + 1'b1 == n_use);
                    end
                end
                ST_OUT: begin
                    if (m_free) begin
                        if (o_last_reg) begin
                            k_reg <= '0;
                        end else begin
                            k_reg <= k_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
            st_reg <= st_next;
        end
    end

    // the closing pair: first tally uses inc vs closing dir, second closing dir vs opening
    always_comb begin
        m_tvalid = o_valid_reg;
        m_tdata  = {2'b00, o_tot_reg, o_hits_reg, o_idx_reg};
        m_tlast  = o_last_reg;
    end
endmodule
`default_nettype wire

FILE: rtl/tah_cordic.sv
`default_nettype none
module tah_cordic #(
    parameter int COORD_WIDTH = tah_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_WIDTH = tah_pkg::ANGLE_WIDTH_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic signed [COORD_WIDTH:0] dx,
    input  wire logic signed [COORD_WIDTH:0] dy,
    output logic                           done,
    output logic [ANGLE_WIDTH-1:0]         angle
);
    import tah_pkg::*;
    // differences scaled by 2^24 and grown by the cordic gain
    localparam int XW = COORD_WIDTH + 1 + 24 + 3;

    logic signed [XW-1:0] x_reg, x_next, y_reg, y_next, xs, ys;
    logic [31:0]          z_reg, z_next, zr;
    logic [STEP_W-1:0]    i_reg, i_next;
    logic                 busy_reg, busy_next, done_reg, done_next;
    logic signed [COORD_WIDTH+1:0] ax, ay;

    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ax = {dx[COORD_WIDTH], dx};
        ay = {dy[COORD_WIDTH], dy};
        xs = x_reg >>> i_reg;
        ys = y_reg >>> i_reg;
        if (start) begin
            if (dx == '0 && dy == '0) begin
                z_next = '0;
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                if (dx < 0) begin
                    ax = -ax;
                    ay = -ay;
                    z_next = 32'h8000_0000;
                end else begin
                    z_next = '0;
                end
                x_next = XW'(ax) <<< 24;
                y_next = XW'(ay) <<< 24;
                i_next = '0;
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (y_reg > 0) begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + arc_lookup(i_reg);
            end else begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - arc_lookup(i_reg);
            end
            i_next = i_reg + 1'b1;
            if (i_reg == STEP_W'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        i_reg <= i_next;
    end

    assign zr    = z_reg + (32'd1 << (31 - ANGLE_WIDTH));
    assign done  = done_reg;
    assign angle = zr[31 -: ANGLE_WIDTH];
endmodule
`default_nettype wire

FILE: rtl/tah_store.sv
`default_nettype none
module tah_store #(
    parameter int MAX_CLASSES = tah_pkg::MAX_CLASSES_DEF,
    parameter int COUNT_WIDTH = tah_pkg::COUNT_WIDTH_DEF,
    parameter int IDX_W       = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1
) (
    input  wire logic                   aclk,
    input  wire logic [IDX_W-1:0]       rd_addr,
    output logic [COUNT_WIDTH-1:0]      rd_data,
    input  wire logic                   wr_en,
    input  wire logic [IDX_W-1:0]       wr_addr,
    input  wire logic [COUNT_WIDTH-1:0] wr_data
);
    logic [COUNT_WIDTH-1:0] mem [MAX_CLASSES];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

FILE: rtl/tah_checker.sv
`default_nettype none
`include "assert_macros.svh"
module tah_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "beat dropped")
    `ASSERT_CLK(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable({m_tlast, m_tdata}), "data moved")
    `ASSERT_CLK(a_no_in_out, aclk, aresetn, m_tvalid |-> !s_tready, "input taken during report")
    `ASSERT_CLK(a_tot_min, aclk, aresetn, m_tvalid |-> m_tdata[37:22] >= 16'd3, "short polygon reported")
    `ASSERT_NORST(a_rst, aclk, !aresetn |=> !m_tvalid, "valid out of reset")
endmodule

bind turn_angle_histogram_unit tah_checker u_tah_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tready(s_tready), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

FILE: dv/turn_angle_histogram_checker.sv
`timescale 1ns / 100ps
module turn_angle_histogram_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [6:0]  cfg_wr_data,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tlast,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [39:0] m_tdata,
    input  wire logic        m_tlast,
    output int               fail_count,
    output int               awaiting
);
    typedef struct packed {
        logic [5:0]  bin_index;
        logic [15:0] bin_hits;
        logic [15:0] vertex_total;
        logic        final_bin;
    } class_report_t;

    localparam logic [31:0] ARC [0:23] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
        32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
        32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
    };

    class_report_t reports_due[$];
    logic [15:0] hits [0:63];
    logic signed [15:0] first_x, first_y, prev_x, prev_y;
    logic [15:0] opening_dir, incoming_dir, points;
    logic [6:0]  bin_cfg;

    function automatic logic [15:0] edge_heading(longint dx, longint dy);
        longint x, y, nx, ny;
        logic [31:0] z;
        z = 32'd0;
        if (dx == 0 && dy == 0) return 16'd0;
        if (dx < 0) begin
            dx = -dx;
            dy = -dy;
            z = 32'h8000_0000;
        end
        x = dx <<< 24;
        y = dy <<< 24;
        for (int i = 0; i < 24; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
                z = z + ARC[i];
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
                z = z - ARC[i];
            end
            x = nx;
            y = ny;
        end
        z = z + 32'h0000_8000;
        return z[31:16];
    endfunction

    function automatic int classes_active();
        if (bin_cfg == 0) return 1;
        if (bin_cfg > 64) return 64;
        return bin_cfg;
    endfunction

    task automatic count_turn(input logic [15:0] in_dir, input logic [15:0] out_dir);
        logic [15:0] a;
        int n, b;
        a = 16'h8000 + in_dir - out_dir;
        n = classes_active();
        b = (int'(a) * n) >> 16;
        if (b >= n) b = n - 1;
        if (hits[b] != 16'hFFFF) hits[b] = hits[b] + 1;
    endtask

    task automatic clear_polygon();
        foreach (hits[i]) hits[i] = '0;
        first_x = '0;
        first_y = '0;
        prev_x = '0;
        prev_y = '0;
        opening_dir = '0;
        incoming_dir = '0;
        points = '0;
    endtask

    task automatic take_vertex(input logic signed [15:0] px, input logic signed [15:0] py,
                               input logic closing);
        logic [15:0] dir;
        class_report_t r;
        int cnt;
        if (points == 0) begin
            first_x = px;
            first_y = py;
        end else begin
            dir = edge_heading(longint'(px) - longint'(prev_x), longint'(py) - longint'(prev_y));
            if (points == 1) opening_dir = dir;
            else count_turn(incoming_dir, dir);
            incoming_dir = dir;
        end
        prev_x = px;
        prev_y = py;
        if (points != 16'hFFFF) points = points + 1;
        if (closing) begin
            if (points >= 3) begin
                dir = edge_heading(longint'(first_x) - longint'(px),
                                   longint'(first_y) - longint'(py));
                count_turn(incoming_dir, dir);
                count_turn(dir, opening_dir);
                cnt = classes_active();
                for (int k = 0; k < cnt; k++) begin
                    r.bin_index = k[5:0];
                    r.bin_hits = hits[k];
                    r.vertex_total = points;
                    r.final_bin = (k + 1 == cnt);
                    reports_due.push_back(r);
                end
            end
            clear_polygon();
        end
    endtask

    initial begin
        fail_count = 0;
        awaiting = 0;
        bin_cfg = 7'd64;
        clear_polygon();
    end

    always @(posedge aclk) begin
        class_report_t got, want;
        if (!aresetn) begin
            clear_polygon();
            bin_cfg <= 7'd64;
        end else begin
            if (cfg_wr_en) bin_cfg <= cfg_wr_data;
            if (s_tvalid && s_tready) take_vertex(s_tdata[15:0], s_tdata[31:16], s_tlast);
            if (m_tvalid && m_tready) begin
                got.bin_index = m_tdata[5:0];
                got.bin_hits = m_tdata[21:6];
                got.vertex_total = m_tdata[37:22];
                got.final_bin = m_tlast;
                if (reports_due.size() == 0) begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected beat: index %0d hits %0d total %0d last %0b",
                                 got.bin_index, got.bin_hits, got.vertex_total, got.final_bin);
                end else begin
                    want = reports_due.pop_front();
                    if (got !== want) begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display({"mismatch: expected index %0d hits %0d total %0d ",
                                      "last %0b, got index %0d hits %0d total %0d last %0b"},
                                     want.bin_index, want.bin_hits, want.vertex_total,
                                     want.final_bin, got.bin_index, got.bin_hits,
                                     got.vertex_total, got.final_bin);
                    end
                end
            end
        end
        awaiting <= reports_due.size();
    end
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [6:0]  cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    int          fail_count, awaiting;
    int          gap_pct = 0, stall_pct = 0;

    always #5 aclk = ~aclk;

    turn_angle_histogram_unit DUT (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    turn_angle_histogram_checker checker_i (
        .aclk(aclk), .aresetn(aresetn), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .fail_count(fail_count), .awaiting(awaiting)
    );

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    // valid stays up after the beat until the next one or an idle cycle replaces it
    task automatic send_vertex(input logic [15:0] x, input logic [15:0] y, input logic last);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {y, x};
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // drain, let the clear sweep finish, then write
    task automatic write_bins(input logic [6:0] value);
        s_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin gap_pct = 0; stall_pct = 0; end
            1: begin gap_pct = 84; stall_pct = 0; end
            2: begin gap_pct = 0; stall_pct = 84; end
            default: begin gap_pct = 9; stall_pct = 9; end
        endcase
    endtask

    task automatic random_polygon(input int nverts, input bit wide);
        logic [15:0] cx, cy;
        int span;
        cx = 16'($urandom);
        cy = 16'($urandom);
        span = $urandom_range(1, 2000);
        for (int v = 0; v < nverts; v++) begin
            if (wide || $urandom_range(9) == 0)
                send_vertex(16'($urandom), 16'($urandom), v == nverts - 1);
            else
                send_vertex(cx + 16'($urandom_range(2 * span) - span),
                            cy + 16'($urandom_range(2 * span) - span), v == nverts - 1);
        end
    endtask

    initial begin
        int sent;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        // extreme corners, default 64 classes
        send_vertex(16'h8000, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h8000, 1'b0);
        send_vertex(16'h7FFF, 16'h7FFF, 1'b0);
        send_vertex(16'h8000, 16'h7FFF, 1'b1);
        // repeated vertex gives a zero-length edge
        send_vertex(16'd5, 16'd5, 1'b0);
        send_vertex(16'd5, 16'd5, 1'b0);
        send_vertex(16'd20, 16'd5, 1'b1);
        // short polygons
        send_vertex(16'd1, 16'd2, 1'b1);
        send_vertex(16'd3, 16'd4, 1'b0);
        send_vertex(16'hFFF0, 16'd9, 1'b1);
        write_bins(7'd0);
        send_vertex(16'd0, 16'd0, 1'b0);
        send_vertex(16'd10, 16'd0, 1'b0);
        send_vertex(16'd0, 16'd10, 1'b1);
        write_bins(7'd127);
        send_vertex(16'd0, 16'd0, 1'b0);
        send_vertex(16'hFFFF, 16'd0, 1'b0);
        send_vertex(16'd0, 16'hFFFF, 1'b1);
        // bin count changed mid-polygon
        write_bins(7'd64);
        send_vertex(16'd0, 16'd0, 1'b0);
        send_vertex(16'd100, 16'd0, 1'b0);
        send_vertex(16'd100, 16'd100, 1'b0);
        write_bins(7'd5);
        send_vertex(16'd50, 16'd150, 1'b0);
        send_vertex(16'd0, 16'd100, 1'b1);
        write_bins(7'd1);
        sent = 0;
        for (int p = 0; sent < 150; p++) begin
            int nv;
            if (p % 6 == 5) begin
                case ($urandom_range(3))
                    0: write_bins(7'd1);
                    1: write_bins(7'd64);
                    2: write_bins(7'd0);
                    default: write_bins(7'($urandom_range(127)));
                endcase
            end
            set_idling(p / 2);
            nv = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 9);
            random_polygon(nv, $urandom_range(3) == 0);
            sent += nv;
        end
        s_tvalid <= 1'b0;
        while (awaiting != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        if (fail_count == 0 && awaiting == 0)
            $display("turn_angle_histogram_unit verification clean");
        else
            $display("turn_angle_histogram_unit verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("turn_angle_histogram_unit verification failed");
        $finish;
    end
endmodule
